### sv/wsd_pkg.sv
// ----------------------------------------------------------------------------
// WebSocket deframer package
// Widths shared by the channel interfaces and the deframer core.
// ----------------------------------------------------------------------------
package wsd_pkg;

   // Width of the held frame length; only the low bits of a 64-bit length
   // are kept when this is narrower than 64 (valid range 16 to 64).
   localparam int LEN_WIDTH = 64;

   localparam int BYTE_W   = 8;
   localparam int OPCODE_W = 4;
   localparam int KEY_W    = 32;
   localparam int HCNT_W   = 4;

   typedef logic [BYTE_W-1:0]    byte_type;
   typedef logic [OPCODE_W-1:0]  opcode_type;
   typedef logic [LEN_WIDTH-1:0] len_type;

endpackage

### sv/wsd_if.sv
// ----------------------------------------------------------------------------
// WebSocket deframer channel interfaces
// Valid/ready channels for the received byte stream and the payload beats.
// ----------------------------------------------------------------------------
interface wsd_req_if;
   import wsd_pkg::*;

   logic     valid;
   logic     ready;
   byte_type data_byte;

   modport source (output valid, output data_byte, input ready);
   modport sink   (input valid, input data_byte, output ready);
endinterface

interface wsd_rsp_if;
   import wsd_pkg::*;

   logic       valid;
   logic       ready;
   byte_type   payload_byte;
   logic       byte_valid;
   opcode_type frame_opcode_out;
   logic       fin_out;
   logic       last_of_frame;

   modport source (output valid, output payload_byte, output byte_valid,
                   output frame_opcode_out, output fin_out, output last_of_frame,
                   input ready);
   modport sink   (input valid, input payload_byte, input byte_valid,
                   input frame_opcode_out, input fin_out, input last_of_frame,
                   output ready);
endinterface

### sv/websocket_frame_deframer.sv
// ----------------------------------------------------------------------------
// WebSocket frame deframer
// Parses received WebSocket frames byte by byte and emits unmasked payload.
// ----------------------------------------------------------------------------
// Usage:
// The req_ch channel carries the received frame stream, one byte per beat.
// Header bytes (first byte, length byte, extended length, mask key) are
// consumed silently. Every payload byte leaves on rsp_ch as one beat,
// XORed with the mask key byte selected by its position modulo four, and
// tagged with the frame's opcode, its FIN bit and a last-of-frame flag.
// A frame of zero length produces a single beat with byte_valid low,
// payload_byte zero and last_of_frame high, on the byte ending its header.
// An accepted byte's result is registered and shows on rsp_ch right after
// the edge that takes it. Throughput is one byte per cycle unless rsp_ch
// stalls; the only state carried between bytes is a small parse register
// set and a length counter whose decrement and zero test set the cycle time.
// Reset (synchronous, active high) returns the parser to waiting for the
// first header byte and drops any pending result beat.
// When the receiver stalls, the result register holds its beat and req_ch
// ready stays low until that beat is taken; in the cycle it is taken, a new
// byte may enter.
// ----------------------------------------------------------------------------
module websocket_frame_deframer (
   input logic         clock,
   input logic         reset,
   wsd_req_if.sink     req_ch,
   wsd_rsp_if.source   rsp_ch
);
   import wsd_pkg::*;

   localparam logic [2:0] PH_HDR0    = 3'd0;
   localparam logic [2:0] PH_HDR1    = 3'd1;
   localparam logic [2:0] PH_EXT16   = 3'd2;
   localparam logic [2:0] PH_EXT64   = 3'd3;
   localparam logic [2:0] PH_MASK    = 3'd4;
   localparam logic [2:0] PH_PAYLOAD = 3'd5;

   localparam logic [6:0]        LEN7_EXT16 = 7'd126;
   localparam logic [6:0]        LEN7_EXT64 = 7'd127;
   localparam logic [HCNT_W-1:0] EXT16_BYTES = HCNT_W'(2);
   localparam logic [HCNT_W-1:0] EXT64_BYTES = HCNT_W'(8);
   localparam logic [HCNT_W-1:0] KEY_BYTES   = HCNT_W'(4);

   // Parser state.
   logic [2:0]        phase_ff, phase_in;
   logic [HCNT_W-1:0] hcnt_ff, hcnt_in;
   opcode_type        opcode_ff, opcode_in;
   logic              fin_ff, fin_in;
   logic              mask_ff, mask_in;
   logic [KEY_W-1:0]  key_ff, key_in;
   len_type           remain_ff, remain_in;
   logic [1:0]        kidx_ff, kidx_in;

   // Result register.
   logic       rsp_valid_ff;
   byte_type   payload_ff;
   logic       bvalid_ff;
   opcode_type rsp_opcode_ff;
   logic       rsp_fin_ff;
   logic       last_ff;

   logic       accept;
   logic       emit;
   byte_type   emit_byte;
   logic       emit_bvalid;
   logic       emit_last;
   logic       len_done;
   logic       hdr_done;
   logic [6:0] len7;
   byte_type   key_byte;
   byte_type   data_b;

   assign data_b        = req_ch.data_byte;
   assign req_ch.ready  = !rsp_valid_ff || rsp_ch.ready;
   assign accept        = req_ch.valid && req_ch.ready;
   assign len7          = data_b[6:0];
   // Key byte 0 sits in the top byte, so the shift is (3 - index) bytes.
   assign key_byte      = BYTE_W'(key_ff >> {~kidx_ff, 3'b000});

   always_comb begin
      phase_in    = phase_ff;
      hcnt_in     = hcnt_ff;
      opcode_in   = opcode_ff;
      fin_in      = fin_ff;
      mask_in     = mask_ff;
      key_in      = key_ff;
      remain_in   = remain_ff;
      kidx_in     = kidx_ff;
      emit        = 1'b0;
      emit_byte   = '0;
      emit_bvalid = 1'b0;
      emit_last   = 1'b0;
      len_done    = 1'b0;
      hdr_done    = 1'b0;

      case (phase_ff)
         PH_HDR1: begin
            mask_in   = data_b[7];
            key_in    = '0;
            hcnt_in   = '0;
            remain_in = '0;
            if (len7 == LEN7_EXT16) begin
               phase_in = PH_EXT16;
            end else if (len7 == LEN7_EXT64) begin
               phase_in = PH_EXT64;
            end else begin
               remain_in = {{(LEN_WIDTH-7){1'b0}}, len7};
               len_done  = 1'b1;
            end
         end
         PH_EXT16, PH_EXT64: begin
            remain_in = {remain_ff[LEN_WIDTH-BYTE_W-1:0], data_b};
            hcnt_in   = hcnt_ff + HCNT_W'(1);
            if (hcnt_in >= ((phase_ff == PH_EXT16) ? EXT16_BYTES : EXT64_BYTES)) begin
               len_done = 1'b1;
            end
         end
         PH_MASK: begin
            key_in  = {key_ff[KEY_W-BYTE_W-1:0], data_b};
            hcnt_in = hcnt_ff + HCNT_W'(1);
            if (hcnt_in >= KEY_BYTES) begin
               hdr_done = 1'b1;
            end
         end
         PH_PAYLOAD: begin
            kidx_in     = kidx_ff + 2'd1;
            remain_in   = remain_ff - LEN_WIDTH'(1);
            emit        = 1'b1;
            emit_byte   = data_b ^ key_byte;
            emit_bvalid = 1'b1;
            emit_last   = (remain_in == '0);
            if (emit_last) begin
               phase_in = PH_HDR0;
            end
         end
         default: begin
            // First header byte, and any phase code with no meaning.
            fin_in    = data_b[7];
            opcode_in = data_b[OPCODE_W-1:0];
            hcnt_in   = '0;
            phase_in  = PH_HDR1;
         end
      endcase

      // The length is complete: go fetch the mask key if there is one.
      if (len_done) begin
         hcnt_in = '0;
         if (mask_in) begin
            phase_in = PH_MASK;
         end else begin
            hdr_done = 1'b1;
         end
      end

      // The header is complete: start the payload, or mark an empty frame.
      if (hdr_done) begin
         hcnt_in = '0;
         kidx_in = '0;
         if (remain_in == '0) begin
            phase_in    = PH_HDR0;
            emit        = 1'b1;
            emit_byte   = '0;
            emit_bvalid = 1'b0;
            emit_last   = 1'b1;
         end else begin
            phase_in = PH_PAYLOAD;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_HDR0;
         hcnt_ff   <= '0;
         opcode_ff <= '0;
         fin_ff    <= 1'b0;
         mask_ff   <= 1'b0;
         key_ff    <= '0;
         remain_ff <= '0;
         kidx_ff   <= '0;
      end else if (accept) begin
         phase_ff  <= phase_in;
         hcnt_ff   <= hcnt_in;
         opcode_ff <= opcode_in;
         fin_ff    <= fin_in;
         mask_ff   <= mask_in;
         key_ff    <= key_in;
         remain_ff <= remain_in;
         kidx_ff   <= kidx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept) begin
         rsp_valid_ff <= emit;
      end else if (rsp_ch.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && emit) begin
         payload_ff    <= emit_byte;
         bvalid_ff     <= emit_bvalid;
         rsp_opcode_ff <= opcode_ff;
         rsp_fin_ff    <= fin_ff;
         last_ff       <= emit_last;
      end
   end

   assign rsp_ch.valid            = rsp_valid_ff;
   assign rsp_ch.payload_byte     = payload_ff;
   assign rsp_ch.byte_valid       = bvalid_ff;
   assign rsp_ch.frame_opcode_out = rsp_opcode_ff;
   assign rsp_ch.fin_out          = rsp_fin_ff;
   assign rsp_ch.last_of_frame    = last_ff;

   // While payload bytes are being counted, at least one is still owed.
   a_payload_nonzero: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_PAYLOAD) |-> (remain_ff != '0))
      else $error("payload phase with zero bytes remaining");

   // A shown end-of-frame beat leaves the parser waiting for a new header.
   a_last_to_hdr0: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && last_ff) |-> (phase_ff == PH_HDR0))
      else $error("end of frame shown but parser not back at first header byte");

   // The empty-frame marker carries a zero byte and always ends its frame.
   a_empty_marker: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !bvalid_ff) |-> (payload_ff == '0 && last_ff))
      else $error("malformed empty-frame marker");

   // A first header byte never produces a beat and always moves to the length byte.
   a_hdr0_step: assert property (@(posedge clock) disable iff (reset)
      (accept && phase_ff == PH_HDR0) |=> (phase_ff == PH_HDR1 && !rsp_valid_ff))
      else $error("first header byte handled wrongly");

   // The header byte counter never runs past the 64-bit length field.
   a_hcnt_bound: assert property (@(posedge clock) disable iff (reset)
      hcnt_ff < EXT64_BYTES)
      else $error("header byte counter out of range");

endmodule

### tb/testbench.sv
// ----------------------------------------------------------------------------
// WebSocket frame deframer testbench
// Feeds byte streams of complete frames into the deframer and checks every
// payload beat against a cycle-free model of the frame parser. The stream
// opens with a few hand-built frames and continues with random frames. The
// random frames vary in length form, masking, header bits and content. The
// sender works in bursts and the receiver stalls, including two long
// hold-offs that back the block up.
// ----------------------------------------------------------------------------
module testbench;
   import wsd_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   // Header length codes that announce an extended length field.
   localparam logic [6:0] LEN_CODE_EXT16 = 7'd126;
   localparam logic [6:0] LEN_CODE_EXT64 = 7'd127;

   localparam int RANDOM_BYTES  = 1950;
   localparam int IDLE_LIMIT    = 5000;
   localparam int HOLD_CYCLES   = 400;
   localparam int REPORT_LIMIT  = 25;

   // Parser phases of the model, in the order a frame header is read.
   typedef enum logic [2:0] {
      PH_FIRST,
      PH_LEN,
      PH_EXT16,
      PH_EXT64,
      PH_KEY,
      PH_PAYLOAD
   } parse_phase_type;

   // Which length form a generated frame uses in its header.
   typedef enum int {
      LEN_SHORT,
      LEN_EXT16,
      LEN_EXT64
   } len_form_type;

   // How the receiver takes result beats during one stretch of the run.
   typedef enum int {
      STALL_NONE,
      STALL_LIGHT,
      STALL_HEAVY,
      STALL_PERIODIC
   } stall_mode_type;

   // One result beat as it appears on the result channel.
   typedef struct packed {
      byte_type   data;
      logic       has_data;
      opcode_type opcode;
      logic       fin;
      logic       last;
   } payload_beat_type;

   logic clock = 1'b0;
   logic reset;

   wsd_req_if req_ch ();
   wsd_rsp_if rsp_ch ();

   websocket_frame_deframer uut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // -------------------------------------------------------------------------
   // Frame parser model. It holds its own copy of the parse state and turns
   // each accepted byte into at most one expected beat.
   // -------------------------------------------------------------------------
   parse_phase_type phase     = PH_FIRST;
   logic [3:0]      hdr_count = '0;
   opcode_type      frame_opcode = '0;
   logic            frame_fin = 1'b0;
   logic            key_present = 1'b0;
   logic [31:0]     key_word = '0;
   len_type         remaining = '0;
   logic [1:0]      key_idx = '0;

   payload_beat_type expected_beats[$];

   // The header is complete: either the frame is empty and yields its marker
   // beat right away, or payload bytes follow.
   task automatic header_complete();
      payload_beat_type beat;
      hdr_count = '0;
      key_idx   = '0;
      if (remaining == '0) begin
         phase         = PH_FIRST;
         beat.data     = '0;
         beat.has_data = 1'b0;
         beat.opcode   = frame_opcode;
         beat.fin      = frame_fin;
         beat.last     = 1'b1;
         expected_beats.insert(expected_beats.size(), beat);
      end else begin
         phase = PH_PAYLOAD;
      end
   endtask

   // The length is known; a mask key may still follow.
   task automatic length_complete();
      hdr_count = '0;
      if (key_present) begin
         phase = PH_KEY;
      end else begin
         header_complete();
      end
   endtask

   task automatic deframe_byte(input byte_type b);
      payload_beat_type beat;
      byte_type         key_byte;
      case (phase)
         PH_LEN: begin
            key_present = b[7];
            key_word    = '0;
            hdr_count   = '0;
            remaining   = '0;
            if (b[6:0] == LEN_CODE_EXT16) begin
               phase = PH_EXT16;
            end else if (b[6:0] == LEN_CODE_EXT64) begin
               phase = PH_EXT64;
            end else begin
               remaining = len_type'(b[6:0]);
               length_complete();
            end
         end
         PH_EXT16, PH_EXT64: begin
            // Big-endian length; only the low LEN_WIDTH bits survive.
            remaining = len_type'({remaining, b});
            hdr_count = hdr_count + 1'b1;
            if (hdr_count >= ((phase == PH_EXT16) ? 4'd2 : 4'd8)) begin
               length_complete();
            end
         end
         PH_KEY: begin
            key_word  = {key_word[23:0], b};
            hdr_count = hdr_count + 1'b1;
            if (hdr_count >= 4'd4) begin
               header_complete();
            end
         end
         PH_PAYLOAD: begin
            // Key byte 0 sits in the top byte of the key word.
            key_byte      = key_word[8*(3-key_idx) +: 8];
            key_idx       = key_idx + 1'b1;
            remaining     = remaining - 1'b1;
            beat.data     = b ^ key_byte;
            beat.has_data = 1'b1;
            beat.opcode   = frame_opcode;
            beat.fin      = frame_fin;
            beat.last     = (remaining == '0);
            if (remaining == '0) begin
               phase = PH_FIRST;
            end
            expected_beats.insert(expected_beats.size(), beat);
         end
         default: begin
            // First header byte; reserved bits are ignored.
            frame_fin    = b[7];
            frame_opcode = b[3:0];
            hdr_count    = '0;
            phase        = PH_LEN;
         end
      endcase
   endtask

   // -------------------------------------------------------------------------
   // Stimulus: the byte stream is built up front as whole frames.
   // -------------------------------------------------------------------------
   byte_type pending_bytes[$];
   int       total_bytes;
   int       frames_built  = 0;
   int       masked_frames = 0;
   int       empty_frames  = 0;
   int       ext16_frames  = 0;
   int       ext64_frames  = 0;

   // Adds one byte to the end of the stream.
   task automatic queue_byte(input byte_type b);
      pending_bytes.insert(pending_bytes.size(), b);
   endtask

   // Appends one frame: header, optional key and n_payload random bytes.
   // n_payload may be shorter than the length only for the last frame.
   task automatic push_frame(input byte_type first, input logic masked,
                             input len_form_type form, input logic [63:0] length,
                             input logic [31:0] key, input int n_payload);
      logic [6:0] code;
      int         i;
      case (form)
         LEN_EXT16: code = LEN_CODE_EXT16;
         LEN_EXT64: code = LEN_CODE_EXT64;
         default:   code = length[6:0];
      endcase
      queue_byte(first);
      queue_byte({masked, code});
      if (form == LEN_EXT16) begin
         for (i = 1; i >= 0; i--) queue_byte(length[8*i +: 8]);
         ext16_frames++;
      end else if (form == LEN_EXT64) begin
         for (i = 7; i >= 0; i--) queue_byte(length[8*i +: 8]);
         ext64_frames++;
      end
      if (masked) begin
         for (i = 3; i >= 0; i--) queue_byte(key[8*i +: 8]);
         masked_frames++;
      end
      for (i = 0; i < n_payload; i++) queue_byte(byte_type'($urandom));
      if (len_type'(length) == '0) empty_frames++;
      frames_built++;
   endtask

   // -------------------------------------------------------------------------
   // Driver: presents bytes from the pending queue in bursts of random length
   // separated by random gaps. Every accepted beat is fed to the model at the
   // edge where it is taken.
   // -------------------------------------------------------------------------
   int bytes_in   = 0;
   int burst_left = 8;
   int gap_left   = 0;

   always @(posedge clock) begin
      if (reset) begin
         req_ch.valid     <= 1'b0;
         req_ch.data_byte <= '0;
      end else begin
         if (req_ch.valid && req_ch.ready) begin
            deframe_byte(req_ch.data_byte);
            bytes_in <= bytes_in + 1;
         end
         // A byte on offer stays put until it is taken.
         if (!req_ch.valid || req_ch.ready) begin
            if (gap_left > 0) begin
               gap_left--;
               req_ch.valid <= 1'b0;
            end else if (pending_bytes.size() > 0) begin
               req_ch.valid     <= 1'b1;
               req_ch.data_byte <= pending_bytes.pop_front();
               burst_left--;
               if (burst_left <= 0) begin
                  burst_left = $urandom_range(1, 40);
                  gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
               end
            end else begin
               req_ch.valid <= 1'b0;
            end
         end
      end
   end

   // -------------------------------------------------------------------------
   // Receiver: switches between stall modes at random intervals. Twice in
   // the run it holds ready low for a long stretch while the sender keeps
   // offering, so the result register fills and the input backs up.
   // -------------------------------------------------------------------------
   stall_mode_type stall_mode   = STALL_NONE;
   int             stretch_left = 100;
   int             hold_left    = 0;
   int             next_hold_at = 600;
   int             holds_done   = 0;
   int             rx_cycle     = 0;

   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         rx_cycle++;
         if (hold_left > 0) begin
            hold_left--;
            rsp_ch.ready <= 1'b0;
         end else if (holds_done < 2 && bytes_in >= next_hold_at) begin
            hold_left = HOLD_CYCLES - 1;
            holds_done++;
            next_hold_at += 800;
            rsp_ch.ready <= 1'b0;
         end else begin
            stretch_left--;
            if (stretch_left <= 0) begin
               stretch_left = $urandom_range(50, 300);
               stall_mode   = stall_mode_type'($urandom_range(0, 3));
            end
            case (stall_mode)
               STALL_LIGHT:    rsp_ch.ready <= ($urandom_range(0, 4) != 0);
               STALL_HEAVY:    rsp_ch.ready <= ($urandom_range(0, 3) == 0);
               STALL_PERIODIC: rsp_ch.ready <= ((rx_cycle % 5) != 0);
               default:        rsp_ch.ready <= 1'b1;
            endcase
         end
      end
   end

   // -------------------------------------------------------------------------
   // Monitor: each accepted result beat is checked field by field against the
   // oldest expected beat.
   // -------------------------------------------------------------------------
   int mismatches   = 0;
   int beats_seen   = 0;

   function automatic void check_field(input string name, input logic [7:0] want,
                                       input logic [7:0] got);
      if (got !== want) begin
         mismatches++;
         if (mismatches <= REPORT_LIMIT) begin
            $display("%0t ns: %s mismatch, expected %h, actual %h", $time, name, want, got);
         end
      end
   endfunction

   always @(posedge clock) begin
      payload_beat_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         beats_seen++;
         if (expected_beats.size() == 0) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT) begin
               $display("%0t ns: unexpected beat, expected none, actual data %h", $time,
                        rsp_ch.payload_byte);
            end
         end else begin
            want = expected_beats.pop_front();
            check_field("payload_byte", want.data, rsp_ch.payload_byte);
            check_field("byte_valid", 8'(want.has_data), 8'(rsp_ch.byte_valid));
            check_field("frame_opcode_out", 8'(want.opcode), 8'(rsp_ch.frame_opcode_out));
            check_field("fin_out", 8'(want.fin), 8'(rsp_ch.fin_out));
            check_field("last_of_frame", 8'(want.last), 8'(rsp_ch.last_of_frame));
         end
      end
   end

   // -------------------------------------------------------------------------
   // Watchdog: a run that stops moving on both channels for too long is a
   // failure.
   // -------------------------------------------------------------------------
   int idle_cycles = 0;

   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("%0t ns: no beat moved for %0d cycles", $time, IDLE_LIMIT);
            $display("simulation failed");
            $finish;
         end
      end
   end

   // -------------------------------------------------------------------------
   // Test sequence.
   // -------------------------------------------------------------------------
   initial begin
      int           pick;
      logic         masked;
      len_form_type form;
      logic [63:0]  length;
      int           n_payload;

      reset = 1'b1;

      // Directed frames: an empty unmasked frame, a one-byte unmasked frame
      // with FIN clear and the top opcode, an empty masked frame, an empty
      // frame with a 16-bit length and reserved bits set, and a one-byte
      // frame with a 64-bit length.
      push_frame(8'h89, 1'b0, LEN_SHORT, 64'd0, 32'h0, 0);
      push_frame(8'h0F, 1'b0, LEN_SHORT, 64'd1, 32'h0, 1);
      push_frame(8'h8A, 1'b1, LEN_SHORT, 64'd0, 32'hFF00A55A, 0);
      push_frame(8'h70, 1'b0, LEN_EXT16, 64'd0, 32'h0, 0);
      push_frame(8'h82, 1'b0, LEN_EXT64, 64'd1, 32'h0, 1);

      // Random frames. Most are well-formed frames of modest length in all
      // three length forms; a tenth are noise with arbitrary length and mask
      // bits. Lengths stay small so that many frame boundaries occur.
      while (pending_bytes.size() < RANDOM_BYTES) begin
         pick   = $urandom_range(0, 99);
         masked = ($urandom_range(0, 9) < 7);
         form   = LEN_SHORT;
         if (pick < 10) begin
            masked = 1'($urandom_range(0, 1));
            length = 64'($urandom_range(0, 125));
         end else if (pick < 60) begin
            pick   = $urandom_range(0, 99);
            length = 64'((pick < 30) ? 0 : (pick < 85) ? $urandom_range(1, 16)
                                                       : $urandom_range(17, 125));
         end else if (pick < 85) begin
            form   = LEN_EXT16;
            length = 64'(($urandom_range(0, 4) == 0) ? $urandom_range(100, 300)
                                                     : $urandom_range(0, 40));
         end else begin
            form   = LEN_EXT64;
            length = 64'($urandom_range(0, 40));
         end
         n_payload = int'(len_type'(length));
         push_frame(byte_type'($urandom), masked, form, length, $urandom, n_payload);
      end

      // The last frame announces a 64-bit length with the top bit set. Only its
      // first bytes are sent, so the frame is still open when the run ends.
      length    = {$urandom, $urandom} | 64'h8000_0000_0000_0000;
      n_payload = (len_type'(length) < 20) ? int'(len_type'(length)) : 20;
      push_frame(byte_type'($urandom), 1'b1, LEN_EXT64, length, $urandom, n_payload);
      total_bytes = pending_bytes.size();

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Wait for every byte to be taken, then for every expected beat, then
      // a short drain in case anything extra comes out.
      while (bytes_in != total_bytes) @(posedge clock);
      while (expected_beats.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);

      $display("Sent %0d bytes in %0d frames (%0d masked, %0d empty, %0d with 16-bit length,",
               total_bytes, frames_built, masked_frames, empty_frames, ext16_frames);
      $display("%0d with 64-bit length); checked %0d result beats, %0d long receiver holds.",
               ext64_frames, beats_seen, holds_done);
      if (mismatches == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

### files.f
sv/wsd_pkg.sv
sv/wsd_if.sv
sv/websocket_frame_deframer.sv
tb/testbench.sv
